// ===== rtl/core/alu8_with_flags_macros.svh =====
// ----------------------------------------------------------------------------
// alu8_with_flags_macros
// Assertion macros shared by the ALU block.
// ----------------------------------------------------------------------------
`ifndef ALU8_WITH_FLAGS_MACROS_SVH
`define ALU8_WITH_FLAGS_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define A8F_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alu8_with_flags: same-cycle check failed");

// check a consequent in the cycle after its antecedent
`define A8F_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alu8_with_flags: next-cycle check failed");

`endif

// ===== rtl/core/alu8f_pkg.sv =====
// ----------------------------------------------------------------------------
// alu8f_pkg
// Word types, operation codes, flag masks and flag helpers for the 8-bit ALU.
// ----------------------------------------------------------------------------
package alu8f_pkg;

   typedef struct packed {
      logic [4:0] cmd;
      logic [7:0] acc_in;
      logic [7:0] flags_in;
      logic [7:0] operand;
   } alu8f_req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [7:0] flags_out;
      logic       write_back;
   } alu8f_rsp_type;

   localparam logic [4:0] CMD_ADD  = 5'd0;
   localparam logic [4:0] CMD_ADC  = 5'd1;
   localparam logic [4:0] CMD_SUB  = 5'd2;
   localparam logic [4:0] CMD_SBC  = 5'd3;
   localparam logic [4:0] CMD_AND  = 5'd4;
   localparam logic [4:0] CMD_XOR  = 5'd5;
   localparam logic [4:0] CMD_OR   = 5'd6;
   localparam logic [4:0] CMD_CP   = 5'd7;
   localparam logic [4:0] CMD_INC  = 5'd8;
   localparam logic [4:0] CMD_DEC  = 5'd9;
   localparam logic [4:0] CMD_DAA  = 5'd10;
   localparam logic [4:0] CMD_CPL  = 5'd11;
   localparam logic [4:0] CMD_SCF  = 5'd12;
   localparam logic [4:0] CMD_CCF  = 5'd13;
   localparam logic [4:0] CMD_RLCA = 5'd14;
   localparam logic [4:0] CMD_RRCA = 5'd15;
   localparam logic [4:0] CMD_RLA  = 5'd16;
   localparam logic [4:0] CMD_RRA  = 5'd17;

   localparam logic [7:0] FLAG_C    = 8'h01;
   localparam logic [7:0] FLAG_N    = 8'h02;
   localparam logic [7:0] FLAG_P    = 8'h04;
   localparam logic [7:0] FLAG_3    = 8'h08;
   localparam logic [7:0] FLAG_H    = 8'h10;
   localparam logic [7:0] FLAG_5    = 8'h20;
   localparam logic [7:0] FLAG_Z    = 8'h40;
   localparam logic [7:0] FLAG_S    = 8'h80;
   localparam logic [7:0] FLAG_KEEP = FLAG_P | FLAG_Z | FLAG_S;
   localparam logic [7:0] FLAG_35   = FLAG_3 | FLAG_5;

   localparam logic [7:0] VAL_MIN_NEG = 8'h80;
   localparam logic [7:0] VAL_MAX_POS = 8'h7f;
   localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
   localparam logic [7:0] DAA_LIMIT   = 8'h99;
   localparam logic [3:0] DAA_DIGIT   = 4'h9;

   function automatic logic [7:0] sz53_of(input logic [7:0] v);
      logic [7:0] f;
      f = v & (FLAG_S | FLAG_35);
      if (v == 8'h00) begin
         f = f | FLAG_Z;
      end
      return f;
   endfunction

   function automatic logic [7:0] szp_of(input logic [7:0] v);
      logic [7:0] f;
      f = sz53_of(v);
      if (!(^v)) begin
         f = f | FLAG_P;
      end
      return f;
   endfunction

endpackage

// ===== rtl/core/alu8_with_flags.sv =====
// ----------------------------------------------------------------------------
// alu8_with_flags
// 8-bit accumulator ALU with full flag generation.
// An accepted word is registered in s1, then its result with rsp_valid.
// Throughput: one word per cycle; busy is high only while reset is held.
// Synchronous reset clears both valid stages; no result is in flight after it.
// The receiver cannot stall: each result is strobed for exactly one cycle.
// ----------------------------------------------------------------------------
`include "alu8_with_flags_macros.svh"

module alu8_with_flags
   import alu8f_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  alu8f_req_type req_data,
   output logic          rsp_valid,
   output alu8f_rsp_type rsp_data
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   alu8f_req_type s1_req_ff;
   logic          rsp_valid_ff;
   alu8f_rsp_type rsp_ff;
   alu8f_rsp_type rsp_in;

   assign busy        = reset;
   assign s1_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_req_ff <= req_data;
      end
      if (s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   alu8f_core u_core (
      .req_data (s1_req_ff),
      .rsp_data (rsp_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `A8F_ASSERT_NOW(a_accept_to_strobe, clock, reset, start && !busy, ##2 rsp_valid)
   `A8F_ASSERT_NOW(a_strobe_has_source, clock, reset, rsp_valid, $past(start && !busy, 2))
   `A8F_ASSERT_NEXT(a_cp_keeps_acc, clock, reset, s1_valid_ff && s1_req_ff.cmd == CMD_CP,
      rsp_valid && !rsp_data.write_back && rsp_data.result == $past(s1_req_ff.acc_in))

endmodule

// ===== rtl/core/alu8f_core.sv =====
// ----------------------------------------------------------------------------
// alu8f_core
// Result and flag logic for one ALU word.
// ----------------------------------------------------------------------------
module alu8f_core
   import alu8f_pkg::*;
(
   input  alu8f_req_type req_data,
   output alu8f_rsp_type rsp_data
);

   logic [7:0] a;
   logic [7:0] b;
   logic [7:0] f;
   logic       cin;
   logic [8:0] sum9;
   logic [8:0] diff9;
   logic [7:0] inc8;
   logic [7:0] dec8;
   logic       daa_lo_big;
   logic       daa_carry;
   logic [7:0] daa_adj;
   logic [7:0] r;
   logic [7:0] nf;
   logic       wb;

   always_comb begin
      a     = req_data.acc_in;
      b     = req_data.operand;
      f     = req_data.flags_in;
      cin   = f[0];
      sum9  = {1'b0, a} + {1'b0, b} + {8'h00, (req_data.cmd == CMD_ADC) & cin};
      diff9 = {1'b0, a} - {1'b0, b} - {8'h00, (req_data.cmd == CMD_SBC) & cin};
      inc8  = b + 8'd1;
      dec8  = b - 8'd1;

      daa_lo_big = (a[3:0] > DAA_DIGIT);
      daa_carry  = cin | (a > DAA_LIMIT);
      daa_adj    = (((f & FLAG_H) != 8'h00) || daa_lo_big ? DAA_LO_ADJ : 8'h00)
                 | (daa_carry ? DAA_HI_ADJ : 8'h00);

      r  = a;
      nf = f;
      wb = 1'b1;

      case (req_data.cmd) inside
         CMD_ADD, CMD_ADC: begin
            r  = sum9[7:0];
            nf = (sum9[8] ? FLAG_C : 8'h00)
               | ((a ^ b ^ sum9[7:0]) & FLAG_H)
               | ((~(a[7] ^ b[7]) & (a[7] ^ sum9[7])) ? FLAG_P : 8'h00)
               | sz53_of(sum9[7:0]);
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            r  = diff9[7:0];
            nf = (diff9[8] ? FLAG_C : 8'h00) | FLAG_N
               | ((a ^ b ^ diff9[7:0]) & FLAG_H)
               | (((a[7] ^ b[7]) & (a[7] ^ diff9[7])) ? FLAG_P : 8'h00);
            if (req_data.cmd == CMD_CP) begin
               nf = nf | (b & FLAG_35) | (diff9[7:0] & FLAG_S)
                  | ((diff9[7:0] == 8'h00) ? FLAG_Z : 8'h00);
               r  = a;
               wb = 1'b0;
            end else begin
               nf = nf | sz53_of(diff9[7:0]);
            end
         end
         CMD_AND: begin
            r  = a & b;
            nf = FLAG_H | szp_of(a & b);
         end
         CMD_XOR: begin
            r  = a ^ b;
            nf = szp_of(a ^ b);
         end
         CMD_OR: begin
            r  = a | b;
            nf = szp_of(a | b);
         end
         CMD_INC: begin
            r  = inc8;
            nf = (f & FLAG_C)
               | ((inc8 == VAL_MIN_NEG) ? FLAG_P : 8'h00)
               | ((inc8[3:0] == 4'h0) ? FLAG_H : 8'h00)
               | sz53_of(inc8);
         end
         CMD_DEC: begin
            r  = dec8;
            nf = (f & FLAG_C) | FLAG_N
               | ((dec8 == VAL_MAX_POS) ? FLAG_P : 8'h00)
               | ((dec8[3:0] == 4'hf) ? FLAG_H : 8'h00)
               | sz53_of(dec8);
         end
         CMD_DAA: begin
            if ((f & FLAG_N) == 8'h00) begin
               r  = a + daa_adj;
               nf = daa_lo_big ? FLAG_H : 8'h00;
            end else begin
               r  = a - daa_adj;
               nf = FLAG_N
                  | ((((f & FLAG_H) != 8'h00) && (a[3:0] < DAA_LO_ADJ[3:0])) ? FLAG_H
                                                                              : 8'h00);
            end
            nf = nf | (daa_carry ? FLAG_C : 8'h00) | szp_of(r);
         end
         CMD_CPL: begin
            r  = ~a;
            nf = (f & (FLAG_C | FLAG_KEEP)) | (~a & FLAG_35) | FLAG_N | FLAG_H;
         end
         CMD_SCF: begin
            nf = (f & FLAG_KEEP) | (a & FLAG_35) | FLAG_C;
         end
         CMD_CCF: begin
            nf = (f & FLAG_KEEP) | (cin ? FLAG_H : FLAG_C) | (a & FLAG_35);
         end
         CMD_RLCA: begin
            r  = {a[6:0], a[7]};
            nf = (f & FLAG_KEEP) | ({a[6:0], a[7]} & (FLAG_C | FLAG_35));
         end
         CMD_RRCA: begin
            r  = {a[0], a[7:1]};
            nf = (f & FLAG_KEEP) | (a & FLAG_C) | ({a[0], a[7:1]} & FLAG_35);
         end
         CMD_RLA: begin
            r  = {a[6:0], cin};
            nf = (f & FLAG_KEEP) | ({a[6:0], cin} & FLAG_35) | {7'h00, a[7]};
         end
         CMD_RRA: begin
            r  = {cin, a[7:1]};
            nf = (f & FLAG_KEEP) | ({cin, a[7:1]} & FLAG_35) | (a & FLAG_C);
         end
         default: begin
            r  = a;
            nf = f;
            wb = 1'b0;
         end
      endcase

      rsp_data.result     = r;
      rsp_data.flags_out  = nf;
      rsp_data.write_back = wb;
   end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8-bit ALU with flag generation. A short table
// of corner words (carry and overflow edges, every operation, undefined
// codes) runs first, then about 1400 random words, among them add/subtract
// words on packed BCD followed by a decimal adjust of their result. Every
// strobed result is compared field by field with a typed row or flag model.
// ----------------------------------------------------------------------------
module tb
   import alu8f_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RANDOM_WORDS   = 1400;
   localparam int         QUIET_WORDS    = 200;
   localparam int         WATCHDOG_LIMIT = 500;
   localparam int         DRAIN_CYCLES   = 4;
   localparam logic [4:0] CMD_UNDEF_LO   = 5'd18;
   localparam logic [4:0] CMD_UNDEF_HI   = 5'd31;

   typedef struct packed {
      alu8f_req_type word;
      logic          typed;
      alu8f_rsp_type rsp;
   } corner_row_type;

   localparam int NUM_CORNERS = 27;
   localparam corner_row_type CORNER_ROWS [NUM_CORNERS] = '{
      '{'{CMD_ADD,  8'h7f, 8'h00, 8'h01}, 1'b1, '{8'h80, 8'h94, 1'b1}},
      '{'{CMD_ADD,  8'hff, 8'h00, 8'h01}, 1'b1, '{8'h00, 8'h51, 1'b1}},
      '{'{CMD_ADC,  8'hff, 8'h01, 8'h00}, 1'b1, '{8'h00, 8'h51, 1'b1}},
      '{'{CMD_SUB,  8'h80, 8'h00, 8'h01}, 1'b1, '{8'h7f, 8'h3e, 1'b1}},
      '{'{CMD_SUB,  8'h00, 8'h00, 8'h01}, 1'b1, '{8'hff, 8'hbb, 1'b1}},
      '{'{CMD_SBC,  8'h00, 8'h01, 8'h00}, 1'b1, '{8'hff, 8'hbb, 1'b1}},
      '{'{CMD_CP,   8'h12, 8'h00, 8'h12}, 1'b1, '{8'h12, 8'h42, 1'b0}},
      '{'{CMD_AND,  8'hff, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h54, 1'b1}},
      '{'{CMD_XOR,  8'h55, 8'h00, 8'haa}, 1'b1, '{8'hff, 8'hac, 1'b1}},
      '{'{CMD_OR,   8'h00, 8'hff, 8'h00}, 1'b1, '{8'h00, 8'h44, 1'b1}},
      '{'{CMD_INC,  8'h00, 8'h01, 8'h7f}, 1'b1, '{8'h80, 8'h95, 1'b1}},
      '{'{CMD_INC,  8'h00, 8'h00, 8'hff}, 1'b1, '{8'h00, 8'h50, 1'b1}},
      '{'{CMD_DEC,  8'h00, 8'h00, 8'h80}, 1'b1, '{8'h7f, 8'h3e, 1'b1}},
      '{'{CMD_DEC,  8'h00, 8'h01, 8'h00}, 1'b1, '{8'hff, 8'hbb, 1'b1}},
      '{'{CMD_DAA,  8'h9a, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h55, 1'b1}},
      '{'{CMD_DAA,  8'h00, 8'h13, 8'h00}, 1'b1, '{8'h9a, 8'h9f, 1'b1}},
      '{'{CMD_CPL,  8'h00, 8'hff, 8'h00}, 1'b1, '{8'hff, 8'hff, 1'b1}},
      '{'{CMD_SCF,  8'hff, 8'h00, 8'h00}, 1'b1, '{8'hff, 8'h29, 1'b1}},
      '{'{CMD_CCF,  8'h00, 8'h01, 8'h00}, 1'b1, '{8'h00, 8'h10, 1'b1}},
      '{'{CMD_RLCA, 8'h80, 8'h00, 8'h00}, 1'b1, '{8'h01, 8'h01, 1'b1}},
      '{'{CMD_RRCA, 8'h01, 8'hff, 8'h00}, 1'b1, '{8'h80, 8'hc5, 1'b1}},
      '{'{CMD_RLA,  8'h80, 8'h01, 8'h00}, 1'b1, '{8'h01, 8'h01, 1'b1}},
      '{'{CMD_RRA,  8'h01, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h01, 1'b1}},
      '{'{CMD_UNDEF_HI, 8'h5a, 8'hc3, 8'h00}, 1'b1, '{8'h5a, 8'hc3, 1'b0}},
      '{'{CMD_UNDEF_LO, 8'ha5, 8'h3c, 8'hff}, 1'b1, '{8'ha5, 8'h3c, 1'b0}},
      '{'{CMD_CP,   8'h40, 8'h00, 8'h28}, 1'b0, '0},
      '{'{CMD_ADC,  8'h3c, 8'h01, 8'h4b}, 1'b0, '0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   alu8f_req_type req_data = '0;
   logic          rsp_valid;
   alu8f_rsp_type rsp_data;

   alu8f_rsp_type pending_results [$];
   int            error_count     = 0;
   int            words_sent      = 0;
   int            results_checked = 0;
   int            undefined_words = 0;
   int            bcd_pairs       = 0;
   int            stall_cycles    = 0;
   bit            idle_on         = 1'b1;
   bit            quiet_tail      = 1'b0;

   alu8_with_flags dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] sign_zero_bits(input logic [7:0] v, input bit with_parity);
      logic [7:0] f;
      f = v & (FLAG_S | FLAG_35);
      if (v == 8'h00) begin
         f = f | FLAG_Z;
      end
      if (with_parity && !(^v)) begin
         f = f | FLAG_P;
      end
      return f;
   endfunction

   function automatic alu8f_rsp_type z80_alu_result(input alu8f_req_type w);
      logic [7:0]    a, b, f, r, nf, adj;
      logic [8:0]    t;
      logic          cin, wb, cy;
      alu8f_rsp_type o;
      a   = w.acc_in;
      b   = w.operand;
      f   = w.flags_in;
      cin = f[0];
      r   = a;
      nf  = f;
      wb  = 1'b1;
      cy  = 1'b0;
      adj = 8'h00;
      case (w.cmd)
         CMD_ADD, CMD_ADC: begin
            t  = {1'b0, a} + {1'b0, b} + {8'h00, (w.cmd == CMD_ADC) ? cin : 1'b0};
            r  = t[7:0];
            nf = sign_zero_bits(r, 1'b0) | ((a ^ b ^ r) & FLAG_H)
               | (t[8] ? FLAG_C : 8'h00);
            if (!(a[7] ^ b[7]) && (a[7] ^ r[7])) begin
               nf = nf | FLAG_P;
            end
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            t  = {1'b0, a} - {1'b0, b} - {8'h00, (w.cmd == CMD_SBC) ? cin : 1'b0};
            r  = t[7:0];
            nf = FLAG_N | ((a ^ b ^ r) & FLAG_H) | (t[8] ? FLAG_C : 8'h00);
            if ((a[7] ^ b[7]) && (a[7] ^ r[7])) begin
               nf = nf | FLAG_P;
            end
            if (w.cmd == CMD_CP) begin
               nf = nf | (b & FLAG_35) | (r & FLAG_S) | ((r == 8'h00) ? FLAG_Z : 8'h00);
               r  = a;
               wb = 1'b0;
            end else begin
               nf = nf | sign_zero_bits(r, 1'b0);
            end
         end
         CMD_AND: begin
            r  = a & b;
            nf = FLAG_H | sign_zero_bits(r, 1'b1);
         end
         CMD_XOR: begin
            r  = a ^ b;
            nf = sign_zero_bits(r, 1'b1);
         end
         CMD_OR: begin
            r  = a | b;
            nf = sign_zero_bits(r, 1'b1);
         end
         CMD_INC: begin
            r  = b + 8'd1;
            nf = {7'd0, cin} | ((r == VAL_MIN_NEG) ? FLAG_P : 8'h00)
               | ((r[3:0] == 4'h0) ? FLAG_H : 8'h00) | sign_zero_bits(r, 1'b0);
         end
         CMD_DEC: begin
            r  = b - 8'd1;
            nf = {7'd0, cin} | ((r[3:0] == 4'hf) ? FLAG_H : 8'h00) | FLAG_N
               | ((r == VAL_MAX_POS) ? FLAG_P : 8'h00) | sign_zero_bits(r, 1'b0);
         end
         CMD_DAA: begin
            if (((f & FLAG_H) != 8'h00) || (a[3:0] > 4'd9)) begin
               adj = DAA_LO_ADJ;
            end
            if (cin || (a > DAA_LIMIT)) begin
               adj = adj | DAA_HI_ADJ;
               cy  = 1'b1;
            end
            if ((f & FLAG_N) == 8'h00) begin
               nf = (a[3:0] > 4'd9) ? FLAG_H : 8'h00;
               r  = a + adj;
            end else begin
               nf = FLAG_N;
               if (((f & FLAG_H) != 8'h00) && (a[3:0] < 4'd6)) begin
                  nf = nf | FLAG_H;
               end
               r = a - adj;
            end
            nf = nf | sign_zero_bits(r, 1'b1) | (cy ? FLAG_C : 8'h00);
         end
         CMD_CPL: begin
            r  = ~a;
            nf = (f & (FLAG_C | FLAG_KEEP)) | (r & FLAG_35) | FLAG_N | FLAG_H;
         end
         CMD_SCF: begin
            nf = (f & FLAG_KEEP) | (a & FLAG_35) | FLAG_C;
         end
         CMD_CCF: begin
            nf = (f & FLAG_KEEP) | (cin ? FLAG_H : FLAG_C) | (a & FLAG_35);
         end
         CMD_RLCA: begin
            r  = {a[6:0], a[7]};
            nf = (f & FLAG_KEEP) | (r & (FLAG_C | FLAG_35));
         end
         CMD_RRCA: begin
            r  = {a[0], a[7:1]};
            nf = (f & FLAG_KEEP) | (a & FLAG_C) | (r & FLAG_35);
         end
         CMD_RLA: begin
            r  = {a[6:0], cin};
            nf = (f & FLAG_KEEP) | (r & FLAG_35) | (a[7] ? FLAG_C : 8'h00);
         end
         CMD_RRA: begin
            r  = {cin, a[7:1]};
            nf = (f & FLAG_KEEP) | (r & FLAG_35) | (a & FLAG_C);
         end
         default: begin
            r  = a;
            nf = f;
            wb = 1'b0;
         end
      endcase
      o.result     = r;
      o.flags_out  = nf;
      o.write_back = wb;
      return o;
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] corners [12];
      corners = '{8'h00, 8'h01, 8'h0f, 8'h10, 8'h7f, 8'h80,
                  8'h81, 8'h99, 8'h9a, 8'hf0, 8'hfe, 8'hff};
      if ($urandom_range(0, 3) == 0) begin
         return corners[$urandom_range(0, 11)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic drive_word(input alu8f_req_type w, input logic typed,
                             input alu8f_rsp_type typed_rsp);
      int gap;
      gap = 0;
      if (idle_on && !quiet_tail && ($urandom_range(0, 3) == 0)) begin
         gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? typed_rsp : z80_alu_result(w));
      words_sent++;
      if (w.cmd > CMD_RRA) begin
         undefined_words++;
      end
   endtask

   always @(posedge clock) begin
      alu8f_rsp_type want;
      if (rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result strobed with nothing outstanding: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_data.result !== want.result) begin
               $error("result: expected %h, got %h", want.result, rsp_data.result);
               error_count++;
            end
            if (rsp_data.flags_out !== want.flags_out) begin
               $error("flags_out: expected %h, got %h", want.flags_out, rsp_data.flags_out);
               error_count++;
            end
            if (rsp_data.write_back !== want.write_back) begin
               $error("write_back: expected %b, got %b", want.write_back,
                      rsp_data.write_back);
               error_count++;
            end
         end
      end
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("alu8_with_flags verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      alu8f_req_type w;
      alu8f_rsp_type sum;
      int            sent_random;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_CORNERS; i++) begin
         drive_word(CORNER_ROWS[i].word, CORNER_ROWS[i].typed, CORNER_ROWS[i].rsp);
      end

      sent_random = 0;
      while (sent_random < RANDOM_WORDS) begin
         if ($urandom_range(0, 49) == 0) begin
            idle_on = !idle_on;
         end
         quiet_tail = (sent_random >= RANDOM_WORDS - QUIET_WORDS);
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               w.cmd      = 5'($urandom_range(CMD_ADD, CMD_SBC));
               w.acc_in   = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
               w.operand  = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
               w.flags_in = 8'($urandom_range(0, 255));
               sum        = z80_alu_result(w);
               drive_word(w, 1'b0, '0);
               w.cmd      = CMD_DAA;
               w.acc_in   = sum.result;
               w.flags_in = sum.flags_out;
               w.operand  = 8'($urandom_range(0, 255));
               drive_word(w, 1'b0, '0);
               bcd_pairs++;
               sent_random += 2;
            end
            4: begin
               w.cmd      = 5'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
               w.acc_in   = pick_byte();
               w.flags_in = 8'($urandom_range(0, 255));
               w.operand  = pick_byte();
               drive_word(w, 1'b0, '0);
               sent_random++;
            end
            default: begin
               w.cmd      = 5'($urandom_range(CMD_ADD, CMD_RRA));
               w.acc_in   = pick_byte();
               w.flags_in = 8'($urandom_range(0, 255));
               w.operand  = pick_byte();
               drive_word(w, 1'b0, '0);
               sent_random++;
            end
         endcase
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words driven (%0d undefined codes, %0d BCD add/sub + adjust pairs)",
               words_sent, undefined_words, bcd_pairs);
      $display("%0d results checked, %0d field mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("alu8_with_flags verification clean");
      end else begin
         $display("alu8_with_flags verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/alu8f_pkg.sv
rtl/core/alu8f_core.sv
rtl/core/alu8_with_flags.sv
bench/tb.sv
